// ===== design/dal_pkg.sv =====
// Shared types and constants for the DNS answer rewrite locator.
// No dependencies; every other design file imports this package.
package dal_pkg;

    localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;

    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;
    localparam logic [15:0] DNS_FLAGS_BYTE   = 16'd2;
    localparam logic [15:0] DNS_ANCOUNT_HI   = 16'd6;
    localparam logic [15:0] DNS_ANCOUNT_LO   = 16'd7;
    localparam logic [15:0] DNS_HEADER_BYTES = 16'd12;
    localparam logic [16:0] ANSWER_ADDR_SKIP = 17'd17;
    localparam logic [6:0]  CHECKSUM_IN_UDP  = 7'd6;
    localparam logic [15:0] IP_PROTO_BYTE    = 16'd9;

    localparam logic [7:0] RESET_REPLACEMENT  = 8'd192;
    localparam logic [1:0] RESET_OCTET_INDEX  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_REPLACEMENT = 1'b0;
    localparam logic CFG_OCTET_INDEX = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_NAME   = 3'b010,
        PH_AFTER  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [7:0] replacement_octet;
        logic [1:0] address_octet_index;
    } cfg_t;

    typedef struct packed {
        logic        rewrite_hit;
        logic [15:0] rewrite_offset;
        logic [7:0]  new_octet;
        logic [6:0]  checksum_offset;
        logic [15:0] packet_length;
    } result_t;

endpackage

// ===== design/dns_answer_rewrite_locator.sv =====
// Top level of the DNS answer rewrite locator: configuration registers and stage wiring.
// Depends on dal_pkg, dal_in_stage, dal_parser and dal_result_reg.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_packet_byte, s_end_of_packet
//   m_        out        m_valid/m_ready    m_rewrite_hit, m_rewrite_offset, m_new_octet,
//                                           m_checksum_offset, m_packet_length
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One byte beat is taken per cycle unless a final byte waits for the output register. A beat
// is registered on entry and parsed from there; the verdict for the final byte of a packet
// is loaded into the output register as that byte moves on, and m_valid rises from there.
// Reset (aresetn low at a clock edge) empties both registers, clears the parse
// state and loads the register defaults. Only the final byte of a packet needs
// room in the output register, so a stalled sink holds back input only once a
// further final byte is waiting; ordinary bytes keep flowing into the parser.
module dns_answer_rewrite_locator import dal_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_packet_byte,
    input  logic        s_end_of_packet,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rewrite_hit,
    output logic [15:0] m_rewrite_offset,
    output logic [7:0]  m_new_octet,
    output logic [6:0]  m_checksum_offset,
    output logic [15:0] m_packet_length,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    cfg_t    cfg_reg;
    beat_t   in_beat;
    beat_t   held_beat;
    logic    held_valid;
    logic    advance;
    logic    out_free;
    result_t verdict;
    result_t out_data;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.replacement_octet   <= RESET_REPLACEMENT;
            cfg_reg.address_octet_index <= RESET_OCTET_INDEX;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REPLACEMENT: cfg_reg.replacement_octet   <= cfg_wdata;
                CFG_OCTET_INDEX: cfg_reg.address_octet_index <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign in_beat.data = s_packet_byte;
    assign in_beat.last = s_end_of_packet;

    // A held byte moves on unless it closes a packet and the verdict slot is full and not being taken.
    assign advance = held_valid && (!held_beat.last || out_free);

    dal_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_beat    (in_beat),
        .advance    (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    dal_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .beat    (held_beat),
        .cfg     (cfg_reg),
        .result  (verdict)
    );

    dal_result_reg u_result_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && held_beat.last),
        .load_data (verdict),
        .free      (out_free),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_rewrite_hit     = out_data.rewrite_hit;
    assign m_rewrite_offset  = out_data.rewrite_offset;
    assign m_new_octet       = out_data.new_octet;
    assign m_checksum_offset = out_data.checksum_offset;
    assign m_packet_length   = out_data.packet_length;

endmodule

// ===== design/dal_in_stage.sv =====
// Input register of the locator: holds one packet byte beat until the parser takes it.
// Depends on dal_pkg for the beat type.
module dal_in_stage import dal_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_beat,
    input  logic  advance,
    output logic  held_valid,
    output beat_t held_beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= in_beat;
        end
    end

endmodule

// ===== design/dal_parser.sv =====
// Per-packet parse state and the single-pass update for one byte, plus the verdict logic.
// Depends on dal_pkg for phases, offsets and the beat, configuration and result types.
module dal_parser import dal_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    commit,
    input  beat_t   beat,
    input  cfg_t    cfg,
    output result_t result
);

    logic [15:0] pos_reg,      pos_next;
    phase_t      phase_reg,    phase_next;
    logic [5:0]  ip_hdr_reg,   ip_hdr_next;
    logic        udp_reg,      udp_next;
    logic        resp_reg,     resp_next;
    logic [15:0] ancount_reg,  ancount_next;
    logic [15:0] name_end_reg, name_end_next;
    logic        term_reg,     term_next;

    logic        parse_en;
    logic [15:0] dns_base;
    logic [16:0] offset_wide;
    logic        hit;

    assign parse_en = (pos_reg != MAX_PACKET_BYTES);
    assign dns_base = 16'(ip_hdr_reg) + UDP_HEADER_BYTES;

    always_comb begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        ip_hdr_next   = ip_hdr_reg;
        udp_next      = udp_reg;
        resp_next     = resp_reg;
        ancount_next  = ancount_reg;
        name_end_next = name_end_reg;
        term_next     = term_reg;
        if (parse_en) begin
            pos_next = pos_reg + 16'd1;
            if (pos_reg == 16'd0) begin
                ip_hdr_next = {beat.data[3:0], 2'b00};
            end
            if (pos_reg == IP_PROTO_BYTE) begin
                udp_next = (beat.data == PROTO_UDP);
            end
            if (phase_reg == PH_HEADER) begin
                if (pos_reg == dns_base + DNS_FLAGS_BYTE) begin
                    resp_next = beat.data[7];
                end
                if (pos_reg == dns_base + DNS_ANCOUNT_HI) begin
                    ancount_next[15:8] = beat.data;
                end
                if (pos_reg == dns_base + DNS_ANCOUNT_LO) begin
                    ancount_next[7:0] = beat.data;
                end
                if (pos_reg == dns_base + DNS_HEADER_BYTES) begin
                    phase_next = PH_NAME;
                end
            end
            // The byte that opens the name may itself be the terminator.
            if (phase_next == PH_NAME && beat.data == 8'd0) begin
                name_end_next = pos_reg;
                term_next     = 1'b1;
                phase_next    = PH_AFTER;
            end
        end
    end

    assign offset_wide = {1'b0, name_end_next} + ANSWER_ADDR_SKIP
                         + 17'(cfg.address_octet_index);
    assign hit = udp_next && resp_next && (ancount_next != 16'd0) && term_next
                 && (offset_wide < {1'b0, pos_next});

    always_comb begin
        result.rewrite_hit     = hit;
        result.rewrite_offset  = hit ? offset_wide[15:0] : 16'd0;
        result.new_octet       = hit ? cfg.replacement_octet : 8'd0;
        result.checksum_offset = hit ? (7'(ip_hdr_next) + CHECKSUM_IN_UDP) : 7'd0;
        result.packet_length   = pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 16'd0;
            phase_reg    <= PH_HEADER;
            ip_hdr_reg   <= 6'd0;
            udp_reg      <= 1'b0;
            resp_reg     <= 1'b0;
            ancount_reg  <= 16'd0;
            name_end_reg <= 16'd0;
            term_reg     <= 1'b0;
        end else if (commit) begin
            if (beat.last) begin
                pos_reg      <= 16'd0;
                phase_reg    <= PH_HEADER;
                ip_hdr_reg   <= 6'd0;
                udp_reg      <= 1'b0;
                resp_reg     <= 1'b0;
                ancount_reg  <= 16'd0;
                name_end_reg <= 16'd0;
                term_reg     <= 1'b0;
            end else begin
                pos_reg      <= pos_next;
                phase_reg    <= phase_next;
                ip_hdr_reg   <= ip_hdr_next;
                udp_reg      <= udp_next;
                resp_reg     <= resp_next;
                ancount_reg  <= ancount_next;
                name_end_reg <= name_end_next;
                term_reg     <= term_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && beat.last |=> pos_reg == 16'd0 && phase_reg == PH_HEADER)
        else $error("parse state not cleared after the final byte");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && !beat.last && !parse_en |=> pos_reg == MAX_PACKET_BYTES)
        else $error("byte count left saturation");

    a_term_after_name: assert property (@(posedge aclk) disable iff (!aresetn)
        term_reg |-> phase_reg == PH_AFTER)
        else $error("name terminated outside the after-name phase");

endmodule

// ===== design/dal_result_reg.sv =====
// Output register of the locator: holds one verdict beat until the sink takes it.
// Depends on dal_pkg for the result type.
module dal_result_reg import dal_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_data,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    a_hit_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && data_reg.rewrite_hit
        |-> data_reg.rewrite_offset < data_reg.packet_length)
        else $error("rewrite offset beyond packet end on a hit");

    a_miss_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.rewrite_hit
        |-> data_reg.rewrite_offset == 16'd0 && data_reg.checksum_offset == 7'd0
            && data_reg.new_octet == 8'd0)
        else $error("miss carries non-zero rewrite fields");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("verdict loaded over an untaken one");

endmodule

// ===== test/dns_answer_rewrite_locator_tb.sv =====
// Self-checking bench for dns_answer_rewrite_locator: streams IPv4/UDP/DNS byte beats and
// checks every packet verdict against an in-bench model of the answer-octet locator or a typed-in verdict.
// Depends on dal_pkg (register indexes, result type, parse phases) and the design sources.
module dns_answer_rewrite_locator_tb;
    import dal_pkg::*;

    // Run shape. The watchdog limit sits well above the long sink hold and the slowest
    // ordinary handshake (the largest source gap plus the largest sink stall plus latency).
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int VERDICT_LATENCY = 2;
    localparam int RANDOM_BYTES    = 300;
    localparam int RANDOM_PHASES   = 6;
    localparam int HOLD_CYCLES     = 400;

    // Packet layout as the locator sees it, kept here independently of the design.
    localparam int unsigned SAT_BYTES      = 65535;
    localparam int unsigned PROTO_BYTE_POS = 9;
    localparam logic [7:0]  UDP_PROTOCOL   = 8'd17;
    localparam int unsigned UDP_HDR        = 8;
    localparam int unsigned FLAGS_POS      = 2;
    localparam int unsigned ANCOUNT_HI_POS = 6;
    localparam int unsigned ANCOUNT_LO_POS = 7;
    localparam int unsigned DNS_HDR        = 12;
    localparam int unsigned ADDR_SKIP      = 17;
    localparam int unsigned CSUM_POS       = 6;
    localparam logic [7:0]  DEFAULT_OCTET  = 8'd192;
    localparam logic [1:0]  DEFAULT_INDEX  = 2'd3;

    // One packet to be built: header fields, name length, bytes after the name's zero byte,
    // and an optional truncation. Rows whose verdict is obvious carry it typed in.
    typedef struct packed {
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  flags;
        logic [15:0] ancount;
        logic [15:0] name_len;
        logic [15:0] tail;
        logic [16:0] cut_len;
        logic        typed;
        result_t     verdict;
    } packet_spec_t;

    localparam result_t NO_VERDICT = '0;

    // Directed packets, walked in order with the register defaults (octet 192, index 3),
    // so a hit needs at least 20 bytes after the name's zero byte.
    localparam packet_spec_t DIRECTED_PACKETS [0:16] = '{
        // ihl  proto  flags  ancount   name     tail    cut      typed  verdict
        // A lone byte: nothing parsed beyond the header length.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd5,  16'd0,  17'd1,  1'b1,
          '{1'b0, 16'd0, 8'd0, 7'd0, 16'd1}},
        // Packet ends with the IP header, before the UDP header.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd5,  16'd0,  17'd20, 1'b1,
          '{1'b0, 16'd0, 8'd0, 7'd0, 16'd20}},
        // Packet ends just before the answer count arrives.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd5,  16'd0,  17'd34, 1'b1,
          '{1'b0, 16'd0, 8'd0, 7'd0, 16'd34}},
        // Rewrite offset is the very last byte: a hit on the boundary.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd5,  16'd20, 17'd0,  1'b0, NO_VERDICT},
        // One byte shorter: rewrite offset past the end.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd5,  16'd19, 17'd0,  1'b0, NO_VERDICT},
        // Not UDP.
        '{4'd5, 8'd6,  8'h80, 16'd1,     16'd5,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        // A query rather than a response.
        '{4'd5, 8'd17, 8'h7f, 16'd1,     16'd5,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        // Response without answers.
        '{4'd5, 8'd17, 8'h80, 16'd0,     16'd5,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        // Answer count carried by its high byte only.
        '{4'd5, 8'd17, 8'h80, 16'h0100,  16'd5,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        // All flag bits and the largest answer count.
        '{4'd5, 8'd17, 8'hff, 16'hffff,  16'd5,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        // Name still running when the packet ends.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd30, 16'd0,  17'd50, 1'b0, NO_VERDICT},
        // Packet cut straight after the name's zero byte.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd4,  16'd0,  17'd45, 1'b0, NO_VERDICT},
        // Root name: the first name byte is already zero.
        '{4'd5, 8'd17, 8'h80, 16'd1,     16'd0,  16'd25, 17'd0,  1'b0, NO_VERDICT},
        // Header lengths below the legal minimum shift everything down.
        '{4'd0, 8'd17, 8'h80, 16'd1,     16'd3,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        '{4'd3, 8'd17, 8'h80, 16'd1,     16'd3,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        '{4'd4, 8'd17, 8'h80, 16'd2,     16'd3,  16'd24, 17'd0,  1'b0, NO_VERDICT},
        // Largest header: the checksum offset reaches its top value.
        '{4'd15, 8'd17, 8'h80, 16'd2,    16'd3,  16'd24, 17'd0,  1'b0, NO_VERDICT}
    };

    logic        aclk;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [7:0]  s_packet_byte     = 8'd0;
    logic        s_end_of_packet   = 1'b0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic        m_rewrite_hit;
    logic [15:0] m_rewrite_offset;
    logic [7:0]  m_new_octet;
    logic [6:0]  m_checksum_offset;
    logic [15:0] m_packet_length;
    logic        cfg_we            = 1'b0;
    logic        cfg_index         = 1'b0;
    logic [7:0]  cfg_wdata         = 8'd0;

    dns_answer_rewrite_locator u_top (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_packet_byte, .s_end_of_packet,
        .m_valid, .m_ready, .m_rewrite_hit, .m_rewrite_offset, .m_new_octet,
        .m_checksum_offset, .m_packet_length,
        .cfg_we, .cfg_index, .cfg_wdata
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Verdicts still owed by the block, oldest first.
    result_t pending_verdicts [$];

    // The packet currently being sent.
    logic [7:0] frame [];

    // Bench copy of the per-packet parse state and of the two registers.
    int unsigned seen_bytes;
    phase_t      scan_phase;
    logic [5:0]  hdr_bytes;
    logic        proto_udp;
    logic        dns_response;
    logic [15:0] answers;
    logic [15:0] name_end;
    logic        name_closed;
    logic [7:0]  cfg_octet;
    logic [1:0]  cfg_octet_idx;

    // Sink control: the largest random stall, and a one-off long hold requested by the
    // stimulus and counted out in the sink's own process.
    int rx_gap_max = 13;
    int rx_hold    = 0;

    int failures         = 0;
    int bytes_sent       = 0;
    int packets_sent     = 0;
    int verdicts_checked = 0;
    int hits_seen        = 0;
    int reg_writes       = 0;
    int idle_cycles      = 0;

    function automatic void clear_parse();
        seen_bytes   = 0;
        scan_phase   = PH_HEADER;
        hdr_bytes    = '0;
        proto_udp    = 1'b0;
        dns_response = 1'b0;
        answers      = '0;
        name_end     = '0;
        name_closed  = 1'b0;
    endfunction

    // Advances the parse by one byte. At the final byte of a packet it returns 1 and the
    // verdict, then clears the parse state for the next packet.
    function automatic bit verdict_for_byte(input logic [7:0] b, input logic eop,
                                            output result_t v);
        int unsigned dns_base;
        int unsigned offs;
        int unsigned len;
        logic        hit;
        v = '0;
        // Once the counter saturates, later bytes are counted no further and not parsed.
        if (seen_bytes < SAT_BYTES) begin
            // The DNS base uses the header length as it stood before this byte.
            dns_base = hdr_bytes + UDP_HDR;
            if (seen_bytes == 0) hdr_bytes = {b[3:0], 2'b00};
            if (seen_bytes == PROTO_BYTE_POS) proto_udp = (b == UDP_PROTOCOL);
            if (scan_phase == PH_HEADER) begin
                if (seen_bytes == dns_base + FLAGS_POS) dns_response = b[7];
                if (seen_bytes == dns_base + ANCOUNT_HI_POS) answers[15:8] = b;
                if (seen_bytes == dns_base + ANCOUNT_LO_POS) answers[7:0] = b;
                if (seen_bytes == dns_base + DNS_HDR) scan_phase = PH_NAME;
            end
            // The first name byte may itself be the zero byte.
            if (scan_phase == PH_NAME && b == 8'h00) begin
                name_end    = seen_bytes[15:0];
                name_closed = 1'b1;
                scan_phase  = PH_AFTER;
            end
            seen_bytes++;
        end
        if (!eop) return 1'b0;
        len  = seen_bytes;
        offs = name_end + ADDR_SKIP + cfg_octet_idx;
        hit  = proto_udp && dns_response && answers != 0 && name_closed && offs < len;
        v.packet_length = len[15:0];
        if (hit) begin
            v.rewrite_hit     = 1'b1;
            v.rewrite_offset  = offs[15:0];
            v.new_octet       = cfg_octet;
            v.checksum_offset = 7'(hdr_bytes + CSUM_POS);
        end
        clear_parse();
        return 1'b1;
    endfunction

    // Lays out a packet from its description. Filler is random, except that the name
    // bytes before the zero byte are never zero.
    function automatic void build_frame(input packet_spec_t spec);
        int unsigned dns_base;
        int unsigned name_start;
        int unsigned term;
        int unsigned total;
        dns_base   = {spec.ihl, 2'b00} + UDP_HDR;
        name_start = dns_base + DNS_HDR;
        term       = name_start + spec.name_len;
        total      = (spec.cut_len != 0) ? spec.cut_len : term + 1 + spec.tail;
        frame = new[total];
        foreach (frame[i]) frame[i] = 8'($urandom);
        frame[0] = {4'h4, spec.ihl};
        if (total > PROTO_BYTE_POS) frame[PROTO_BYTE_POS] = spec.proto;
        if (total > dns_base + FLAGS_POS) frame[dns_base + FLAGS_POS] = spec.flags;
        if (total > dns_base + ANCOUNT_HI_POS) begin
            frame[dns_base + ANCOUNT_HI_POS] = spec.ancount[15:8];
        end
        if (total > dns_base + ANCOUNT_LO_POS) begin
            frame[dns_base + ANCOUNT_LO_POS] = spec.ancount[7:0];
        end
        for (int unsigned i = name_start; i < term && i < total; i++) begin
            frame[i] = 8'($urandom_range(1, 255));
        end
        if (term < total) frame[term] = 8'h00;
    endfunction

    function automatic void noise_frame(input int unsigned len);
        frame = new[len];
        foreach (frame[i]) frame[i] = 8'($urandom);
    endfunction

    // Mostly well-formed DNS responses with random content; some fields are spoilt now and
    // then, the answer count is sometimes zero and some packets are cut short.
    function automatic packet_spec_t random_spec();
        packet_spec_t spec;
        int unsigned  span;
        spec       = '0;
        spec.ihl   = ($urandom_range(0, 4) != 0) ? 4'd5 : 4'($urandom_range(0, 15));
        spec.proto = ($urandom_range(0, 6) != 0) ? UDP_PROTOCOL : 8'($urandom);
        spec.flags = 8'($urandom);
        if ($urandom_range(0, 4) != 0) spec.flags[7] = 1'b1;
        case ($urandom_range(0, 9))
            0:       spec.ancount = 16'd0;
            1:       spec.ancount = 16'($urandom);
            default: spec.ancount = 16'($urandom_range(1, 3));
        endcase
        spec.name_len = 16'($urandom_range(0, 24));
        // Around the boundary: the rewrite offset lies 17 to 20 bytes past the zero byte.
        spec.tail = 16'($urandom_range(12, 30));
        if ($urandom_range(0, 6) == 0) begin
            span = {spec.ihl, 2'b00} + UDP_HDR + DNS_HDR + spec.name_len + 1 + spec.tail;
            spec.cut_len = 17'($urandom_range(1, span));
        end
        return spec;
    endfunction

    // Offers one beat after an optional gap and holds it until the block takes it. Entered
    // and left just after a falling edge, so every change lands on a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic eop, input int gap,
                             input logic typed, input result_t typed_verdict);
        result_t v;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_packet_byte   <= b;
        s_end_of_packet <= eop;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        bytes_sent++;
        if (verdict_for_byte(b, eop, v)) pending_verdicts.push_back(typed ? typed_verdict : v);
        @(negedge aclk);
    endtask

    task automatic send_frame(input bit bursty, input logic typed, input result_t typed_verdict);
        foreach (frame[i]) begin
            push_byte(frame[i], i == frame.size() - 1, bursty ? $urandom_range(0, 13) : 0,
                      typed, typed_verdict);
        end
        packets_sent++;
    endtask

    // The source stops, every owed verdict is collected, and the bench waits on so the
    // block is idle before anything about it is changed.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge aclk);
        repeat (VERDICT_LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_REPLACEMENT) begin
            cfg_octet = value;
        end else begin
            cfg_octet_idx = value[1:0];
        end
        reg_writes++;
        @(negedge aclk);
    endtask

    // Result sink: a random stall before each verdict beat, none at all when rx_gap_max is
    // zero, and once a long hold so that verdicts back up and the block stalls its input.
    initial begin : verdict_sink
        int stall;
        @(negedge aclk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            repeat (stall) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_valid);
            @(negedge aclk);
        end
    end

    // Every verdict beat is compared field by field with the oldest owed verdict.
    always @(posedge aclk) begin : verdict_check
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_rewrite_hit, m_rewrite_offset, m_new_octet, m_checksum_offset,
                   m_packet_length};
            if (pending_verdicts.size() == 0) begin
                $error("verdict beat with none owed (packet_length %0d)", m_packet_length);
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (want.rewrite_hit) hits_seen++;
                if (got.rewrite_hit !== want.rewrite_hit) begin
                    $error("rewrite_hit: expected %0d, got %0d", want.rewrite_hit,
                           got.rewrite_hit);
                    failures++;
                end
                if (got.rewrite_offset !== want.rewrite_offset) begin
                    $error("rewrite_offset: expected %0d, got %0d", want.rewrite_offset,
                           got.rewrite_offset);
                    failures++;
                end
                if (got.new_octet !== want.new_octet) begin
                    $error("new_octet: expected %0d, got %0d", want.new_octet, got.new_octet);
                    failures++;
                end
                if (got.checksum_offset !== want.checksum_offset) begin
                    $error("checksum_offset: expected %0d, got %0d", want.checksum_offset,
                           got.checksum_offset);
                    failures++;
                end
                if (got.packet_length !== want.packet_length) begin
                    $error("packet_length: expected %0d, got %0d", want.packet_length,
                           got.packet_length);
                    failures++;
                end
            end
        end
    end

    // Watchdog: any stretch as long as the watchdog limit with no beat accepted on either channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int  target;
        bit  bursty;
        clear_parse();
        cfg_octet     = DEFAULT_OCTET;
        cfg_octet_idx = DEFAULT_INDEX;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed packets with the register defaults still in place.
        foreach (DIRECTED_PACKETS[r]) begin
            build_frame(DIRECTED_PACKETS[r]);
            send_frame(1'b1, DIRECTED_PACKETS[r].typed, DIRECTED_PACKETS[r].verdict);
        end
        settle();

        // Back-pressure: the sink holds off for a long stretch while the source keeps
        // sending short packets back to back, so verdicts pile up and input stalls.
        rx_hold = HOLD_CYCLES;
        repeat (40) begin
            noise_frame($urandom_range(1, 4));
            send_frame(1'b0, 1'b0, NO_VERDICT);
        end
        settle();

        // Random traffic in phases, each with its own register setting. The extremes of
        // both registers come first; every third phase the sink never stalls.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_REPLACEMENT, 8'd0);
                    write_reg(CFG_OCTET_INDEX, 8'd0);
                end
                1: begin
                    write_reg(CFG_REPLACEMENT, 8'd255);
                    write_reg(CFG_OCTET_INDEX, 8'd3);
                end
                2: begin
                    write_reg(CFG_REPLACEMENT, 8'($urandom));
                    write_reg(CFG_OCTET_INDEX, 8'd1);
                end
                3: begin
                    write_reg(CFG_REPLACEMENT, 8'($urandom));
                    write_reg(CFG_OCTET_INDEX, 8'd2);
                end
                default: begin
                    write_reg(CFG_REPLACEMENT, 8'($urandom));
                    write_reg(CFG_OCTET_INDEX, 8'($urandom_range(0, 3)));
                end
            endcase
            rx_gap_max = (p % 3 == 2) ? 0 : 13;
            target     = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
            while (bytes_sent < target) begin
                bursty = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) < 7) begin
                    build_frame(random_spec());
                end else begin
                    noise_frame($urandom_range(1, 40));
                end
                send_frame(bursty, 1'b0, NO_VERDICT);
            end
            settle();
        end

        // Quiet tail: any stray verdict beat arriving now is caught by the checker.
        repeat (4 * VERDICT_LATENCY) @(negedge aclk);

        $display("Checked %0d verdicts (%0d rewrite hits) over %0d packets and %0d byte beats.",
                 verdicts_checked, hits_seen, packets_sent, bytes_sent);
        $display("Covered truncated, malformed and noise packets, sink hold-off and %0d %s",
                 reg_writes, "register writes across both register extremes.");
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
